// ===== rtl/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property forms; the using module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Request/response payload types, codes and controller/datapath links.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int REQ_W      = 3;
    localparam int IN_WORD_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_WORD_W = 32;
    localparam int FILL_W     = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [IN_WORD_W-1:0] push_word;
    } deq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_WORD_W-1:0] read_word;
        logic [FILL_W-1:0]     fill_count;
    } deq_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_peek;
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic peek_hit;
    } deq_stat_t;

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: capture, execute, optional peek read, result strobe.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output deq_pkg::deq_cmd_t cmd,
    input  deq_pkg::deq_stat_t stat
);
    import deq_pkg::*;

    `include "double_ended_queue_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PEEK
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.peek_hit)
                begin
                    state_next = ST_PEEK;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_PEEK:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign cmd.capture   = (state_reg == ST_IDLE) && start;
    assign cmd.execute   = (state_reg == ST_EXEC);
    assign cmd.load_peek = (state_reg == ST_PEEK);

    `DEQ_ASSERT_NEXT(a_exec_done, state_reg == ST_EXEC && !stat.peek_hit,
        done_reg && state_reg == ST_IDLE, "non-peek request did not finish")
    `DEQ_ASSERT_NEXT(a_peek_done, state_reg == ST_PEEK,
        done_reg && state_reg == ST_IDLE, "peek read did not finish")
    `DEQ_ASSERT_NEXT(a_accept_exec, state_reg == ST_IDLE && start,
        state_reg == ST_EXEC && !done_reg, "accepted request not executed")

endmodule

// ===== rtl/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, front pointer, entry count and result register.
// ----------------------------------------------------------------------------
module deq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_req_t  req,
    input  deq_pkg::deq_cmd_t  cmd,
    output deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_rsp_t  rsp
);
    import deq_pkg::*;

    `include "double_ended_queue_assert.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    deq_req_t         req_reg;
    deq_rsp_t         rsp_reg;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                empty, full, is_push, is_peek;
    logic [PTR_W-1:0]    front_inc, front_dec, back_wr, back_rd;
    logic [SUM_W-1:0]    sum_wr, sum_rd;
    logic [STATUS_W-1:0] status_v;
    logic                ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [WORD_WIDTH-1:0] ram_rd_data;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_C);
    assign is_push = (req_reg.req_type == REQ_PUSH_FRONT) ||
                     (req_reg.req_type == REQ_PUSH_BACK);
    assign is_peek = (req_reg.req_type == REQ_PEEK_FRONT) ||
                     (req_reg.req_type == REQ_PEEK_BACK);

    assign front_inc = (front_reg == LAST_POS) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;

    // front + count (< 2*depth), wrapped with one compare and subtract
    assign sum_wr  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_wr = (sum_wr >= DEPTH_S) ? PTR_W'(sum_wr - DEPTH_S) : PTR_W'(sum_wr);
    assign sum_rd  = sum_wr - 1'b1;
    assign back_rd = (sum_rd >= DEPTH_S) ? PTR_W'(sum_rd - DEPTH_S) : PTR_W'(sum_rd);

    assign stat.peek_hit = is_peek && !empty;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_v    = STATUS_OK;
        ram_wr_en   = 1'b0;
        ram_wr_addr = back_wr;
        ram_rd_en   = 1'b0;
        ram_rd_addr = front_reg;
        if (cmd.execute)
        begin
            unique case (req_reg.req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_v = STATUS_FULL;
                    end
                    else
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (req_reg.req_type == REQ_PUSH_FRONT)
                        begin
                            ram_wr_addr = front_dec;
                            front_next  = front_dec;
                        end
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_v = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (req_reg.req_type == REQ_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                REQ_PEEK_FRONT, REQ_PEEK_BACK:
                begin
                    if (empty)
                    begin
                        status_v = STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_rd_en = 1'b1;
                        if (req_reg.req_type == REQ_PEEK_BACK)
                        begin
                            ram_rd_addr = back_rd;
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    // unused code: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.execute)
        begin
            rsp_reg.status     <= status_v;
            rsp_reg.read_word  <= '0;
            rsp_reg.fill_count <= FILL_W'(count_next);
        end
        else if (cmd.load_peek)
        begin
            rsp_reg.read_word <= OUT_WORD_W'(ram_rd_data);
        end
    end

    assign rsp = rsp_reg;

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (WORD_WIDTH'(req_reg.push_word)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C,
        "entry count above queue depth")
    `DEQ_ASSERT_NEXT(a_full_hold, cmd.execute && is_push && full,
        $stable(count_reg) && $stable(front_reg), "push into full queue changed state")

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended word queue in a ring RAM with front pointer and entry count.
// ----------------------------------------------------------------------------
//  channel   ports             transfer
//  request   start, req        start high while busy low
//  result    done, rsp         done high, one cycle, no back-pressure
//
//  Push, pop, clear and unused codes go from accept through the execute state to done;
//  a successful peek also passes the peek state, for the registered RAM read.
//  busy stays high until the cycle done rises, so a new request can be
//  taken in the same cycle the previous result is shown.
//  Reset empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_req_t req,
    output logic              done,
    output deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    deq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
